>>> hw/rtl/binary_to_decimal_ascii_assert.svh
// Assertion macros for the binary_to_decimal_ascii checker.
// No dependencies; clk_i and rst_ni must be visible where a macro is used.
`ifndef BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define B2DA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("b2da: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define B2DA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("b2da: next-cycle check failed");

`endif

>>> hw/rtl/b2da_pkg.sv
// Shared types and constants for the binary to decimal ASCII converter.
// No dependencies.
package b2da_pkg;

  // Double-dabble steps done by one pipeline stage.
  localparam int unsigned DABBLE_STEPS = 8;

  localparam logic [7:0] DIGIT_BASE = 8'h30;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  typedef enum logic [2:0] {
    SER_IDLE,
    SER_DIGIT,
    SER_LF,
    SER_CR,
    SER_NUL
  } ser_state_e;

endpackage

>>> hw/rtl/binary_to_decimal_ascii.sv
// Top level of the unsigned binary to decimal ASCII converter.
// Depends on b2da_pkg, b2da_dabble_stage and b2da_serializer.
//
// A transaction is accepted on a rising edge with start_i high and busy_o low.
// The value goes through ceil(VALUE_BITS/8) double-dabble register stages
// (4 at the default width), then the serializer, which loads it once free
// and then puts the first byte on the output ports; each byte is taken at
// the edge that ends the cycle in which it is shown. A value with d decimal
// digits gives d + 3 bytes on consecutive cycles, marked by strobe_o: the
// digits most significant first with no leading zeros (zero gives one '0'),
// then LF, CR and NUL, with last_byte_o high on the NUL. The serializer
// emits one byte per cycle and so sets the sustained rate; bytes of
// back-to-back transactions follow with no gap. Transactions can enter on
// consecutive cycles until the stages fill up behind the serializer, after
// which busy_o holds the source off. The receiver cannot stall: each byte is
// valid for exactly the one cycle its strobe is high.
module binary_to_decimal_ascii import b2da_pkg::*; #(
  parameter int unsigned VALUE_BITS = 31
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  busy_o,
  output logic                  strobe_o,
  output logic [7:0]            text_byte_o,
  output logic                  last_byte_o
);

  // floor(VALUE_BITS * log10(2)) + 1 digits cover the largest value.
  localparam int unsigned NUM_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int unsigned NUM_STAGES = (VALUE_BITS + DABBLE_STEPS - 1) / DABBLE_STEPS;
  localparam int unsigned LAST_STEPS = VALUE_BITS - DABBLE_STEPS * (NUM_STAGES - 1);
  localparam int unsigned W          = NUM_DIGITS * 4 + VALUE_BITS;

  logic [NUM_STAGES-1:0] stage_valid;
  logic [NUM_STAGES:0]   stage_free;
  logic [W-1:0]          stage_data [NUM_STAGES];
  logic                  ser_ready;

  // A stage takes a new transaction when it is empty or its contents move on.
  assign stage_free[NUM_STAGES] = ser_ready;

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
    localparam int unsigned STEPS = (k == NUM_STAGES - 1) ? LAST_STEPS : DABBLE_STEPS;

    logic         in_valid;
    logic [W-1:0] in_data;

    assign stage_free[k] = !stage_valid[k] || stage_free[k+1];

    if (k == 0) begin : g_head
      // Seed with an all-zero BCD field above the binary value.
      assign in_valid = start_i;
      assign in_data  = {{(NUM_DIGITS*4){1'b0}}, value_i};
    end else begin : g_body
      assign in_valid = stage_valid[k-1];
      assign in_data  = stage_data[k-1];
    end

    b2da_dabble_stage #(
      .VALUE_BITS (VALUE_BITS),
      .NUM_DIGITS (NUM_DIGITS),
      .STEPS      (STEPS)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .load_i  (stage_free[k]),
      .valid_i (in_valid),
      .data_i  (in_data),
      .valid_o (stage_valid[k]),
      .data_o  (stage_data[k])
    );
  end

  // Hold off the source while the first stage is full and stuck.
  assign busy_o = !stage_free[0];

  // After all steps the BCD digits sit in the upper part of the word.
  b2da_serializer #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (stage_valid[NUM_STAGES-1]),
    .bcd_i       (stage_data[NUM_STAGES-1][W-1 -: NUM_DIGITS*4]),
    .ready_o     (ser_ready),
    .strobe_o    (strobe_o),
    .text_byte_o (text_byte_o),
    .last_byte_o (last_byte_o)
  );

endmodule

>>> hw/rtl/b2da_dabble_stage.sv
// One register stage of the double-dabble binary to BCD pipeline.
// Depends on b2da_pkg for the default number of steps per stage.
module b2da_dabble_stage import b2da_pkg::*; #(
  parameter int unsigned VALUE_BITS = 31,
  parameter int unsigned NUM_DIGITS = 10,
  parameter int unsigned STEPS      = DABBLE_STEPS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 load_i,
  input  logic                                 valid_i,
  input  logic [NUM_DIGITS*4+VALUE_BITS-1:0]   data_i,
  output logic                                 valid_o,
  output logic [NUM_DIGITS*4+VALUE_BITS-1:0]   data_o
);

  localparam int unsigned W = NUM_DIGITS * 4 + VALUE_BITS;

  logic         valid_q;
  logic [W-1:0] data_q;
  logic [W-1:0] data_d;

  // Correct every BCD digit of five or more, then shift one binary bit in.
  function automatic logic [W-1:0] dabble(input logic [W-1:0] x);
    logic [W-1:0] y;
    y = x;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (y[VALUE_BITS+4*d +: 4] >= 4'd5) begin
        y[VALUE_BITS+4*d +: 4] = y[VALUE_BITS+4*d +: 4] + 4'd3;
      end
    end
    return {y[W-2:0], 1'b0};
  endfunction

  always_comb begin
    data_d = data_i;
    for (int s = 0; s < STEPS; s++) begin
      data_d = dabble(data_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> hw/rtl/b2da_serializer.sv
// Byte serializer: emits the BCD digits without leading zeros, then LF, CR, NUL.
// Depends on b2da_pkg for the state type and character constants.
module b2da_serializer import b2da_pkg::*; #(
  parameter int unsigned NUM_DIGITS = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [NUM_DIGITS*4-1:0] bcd_i,
  output logic                    ready_o,
  output logic                    strobe_o,
  output logic [7:0]              text_byte_o,
  output logic                    last_byte_o
);

  localparam int unsigned IDX_W = $clog2(NUM_DIGITS);

  ser_state_e       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] msd;
  logic [3:0]       digits_q [NUM_DIGITS];
  logic [3:0]       digit;
  logic             load;

  assign ready_o = (state_q == SER_IDLE) || (state_q == SER_NUL);
  assign load    = valid_i && ready_o;

  // Highest nonzero digit; zero reads as a single digit.
  always_comb begin
    msd = '0;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd_i[4*d +: 4] != 4'd0) begin
        msd = IDX_W'(d);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      SER_IDLE:  if (load) state_d = SER_DIGIT;
      SER_DIGIT: if (idx_q == '0) state_d = SER_LF;
      SER_LF:    state_d = SER_CR;
      SER_CR:    state_d = SER_NUL;
      SER_NUL:   state_d = load ? SER_DIGIT : SER_IDLE;
      default:   state_d = SER_IDLE;
    endcase
  end

  always_comb begin
    if (load) begin
      idx_d = msd;
    end else if (state_q == SER_DIGIT) begin
      idx_d = idx_q - 1'b1;
    end else begin
      idx_d = idx_q;
    end
  end

  assign digit = digits_q[idx_q];

  always_comb begin
    strobe_o    = 1'b1;
    text_byte_o = CHAR_NUL;
    last_byte_o = 1'b0;
    case (state_q)
      SER_DIGIT: text_byte_o = DIGIT_BASE + {4'h0, digit};
      SER_LF:    text_byte_o = CHAR_LF;
      SER_CR:    text_byte_o = CHAR_CR;
      SER_NUL:   last_byte_o = 1'b1;
      default:   strobe_o    = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SER_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        digits_q[d] <= bcd_i[4*d +: 4];
      end
    end
  end

endmodule

>>> hw/rtl/b2da_checker.sv
// Port-level checker for binary_to_decimal_ascii, bound to the top level.
// Depends on b2da_pkg and on binary_to_decimal_ascii_assert.svh for the macros.
`include "binary_to_decimal_ascii_assert.svh"

module b2da_checker import b2da_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       busy_o,
  input logic       strobe_o,
  input logic [7:0] text_byte_o,
  input logic       last_byte_o
);

  logic is_digit;
  logic is_lf;
  logic is_cr;

  assign is_digit = strobe_o && (text_byte_o >= DIGIT_BASE) &&
                    (text_byte_o <= DIGIT_BASE + 8'd9);
  assign is_lf    = strobe_o && (text_byte_o == CHAR_LF);
  assign is_cr    = strobe_o && (text_byte_o == CHAR_CR);

  // Only the NUL terminator carries the last flag.
  `B2DA_ASSERT_NOW(a_last_is_nul, strobe_o && last_byte_o, text_byte_o == CHAR_NUL)
  // Digits run on without a gap until the line feed.
  `B2DA_ASSERT_NEXT(a_digit_run, is_digit, is_digit || is_lf)
  // Line feed is followed by carriage return.
  `B2DA_ASSERT_NEXT(a_lf_cr, is_lf, is_cr)
  // Carriage return is followed by the terminating NUL.
  `B2DA_ASSERT_NEXT(a_cr_nul, is_cr, strobe_o && last_byte_o && (text_byte_o == CHAR_NUL))
  // The source is held off only while a string is mid-flight on the output.
  `B2DA_ASSERT_NOW(a_busy_emitting, busy_o, strobe_o && !last_byte_o)

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .busy_o      (busy_o),
  .strobe_o    (strobe_o),
  .text_byte_o (text_byte_o),
  .last_byte_o (last_byte_o)
);

>>> verif/binary_to_decimal_ascii_test.sv
// Self-checking testbench for the binary to decimal ASCII converter.
// Depends on b2da_pkg and binary_to_decimal_ascii; checks every text byte against a local model.
module binary_to_decimal_ascii_test;
  import b2da_pkg::*;

  localparam int unsigned VALUE_BITS = 31;
  localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};
  localparam int unsigned RANDOM_ITEMS = 150;
  localparam int unsigned DRAIN_CYCLES = 40;

  // One pending conversion: the value, the idle cycles to insert before it,
  // and whether to hold it until every queued byte has come out.
  typedef struct {
    logic [VALUE_BITS-1:0] value;
    int unsigned           gap;
    bit                    drain_first;
  } value_item_t;

  // One predicted output byte.
  typedef struct {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic [VALUE_BITS-1:0] value_i = '0;
  logic                  busy_o;
  logic                  strobe_o;
  logic [7:0]            text_byte_o;
  logic                  last_byte_o;

  value_item_t pending_values[$];
  text_char_t  expected_text[$];
  int unsigned error_count = 0;

  binary_to_decimal_ascii #(
    .VALUE_BITS(VALUE_BITS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .value_i    (value_i),
    .busy_o     (busy_o),
    .strobe_o   (strobe_o),
    .text_byte_o(text_byte_o),
    .last_byte_o(last_byte_o)
  );

  always #4 clk_i = ~clk_i;

  // Append the decimal text of one value to the expected byte stream:
  // digits most significant first without leading zeros, then LF, CR, NUL.
  function automatic void queue_decimal_text(input logic [VALUE_BITS-1:0] value);
    logic [7:0]  digit_codes[20];
    longint unsigned rest;
    int          num_digits;
    text_char_t  ch;
    rest = value;
    num_digits = 0;
    // Collect least significant first; zero still yields one digit.
    while (num_digits == 0 || rest != 0) begin
      digit_codes[num_digits] = DIGIT_BASE + 8'(rest % 10);
      rest = rest / 10;
      num_digits++;
    end
    for (int d = num_digits - 1; d >= 0; d--) begin
      ch.code = digit_codes[d];
      ch.last = 1'b0;
      expected_text.push_back(ch);
    end
    ch.code = CHAR_LF;
    ch.last = 1'b0;
    expected_text.push_back(ch);
    ch.code = CHAR_CR;
    expected_text.push_back(ch);
    ch.code = CHAR_NUL;
    ch.last = 1'b1;
    expected_text.push_back(ch);
  endfunction

  task automatic add_value(input logic [VALUE_BITS-1:0] value, input int unsigned gap,
                           input bit drain_first);
    value_item_t item;
    item.value = value;
    item.gap = gap;
    item.drain_first = drain_first;
    pending_values.push_back(item);
  endtask

  // Mostly back-to-back, often a short pause, now and then a long one.
  function automatic int unsigned random_gap();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) begin
      return 0;
    end else if (pick < 85) begin
      return $urandom_range(3, 1);
    end else if (pick < 97) begin
      return $urandom_range(12, 4);
    end
    return $urandom_range(60, 20);
  endfunction

  // Pick a digit count first so that short and long numbers are equally
  // common, then a value inside that decade.
  function automatic logic [VALUE_BITS-1:0] random_value();
    longint unsigned decade_low;
    longint unsigned decade_high;
    int unsigned     num_digits;
    int unsigned     pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      return VALUE_BITS'($urandom());
    end
    num_digits = $urandom_range(10, 1);
    decade_low = 1;
    for (int i = 1; i < num_digits; i++) begin
      decade_low = decade_low * 10;
    end
    decade_high = decade_low * 10 - 1;
    if (num_digits == 1) begin
      decade_low = 0;
    end
    if (decade_high > VALUE_MAX) begin
      decade_high = VALUE_MAX;
    end
    return VALUE_BITS'($urandom_range(32'(decade_high), 32'(decade_low)));
  endfunction

  // Driver: a transaction completes on an edge with start high and busy low.
  // Predict its text at that edge, then present the next value or go idle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        queue_decimal_text(value_i);
      end
      if (!start_i || !busy_o) begin
        if (pending_values.size() != 0 && pending_values[0].gap != 0) begin
          // Count down the gap in front of the next value with start low.
          pending_values[0].gap = pending_values[0].gap - 1;
          start_i <= 1'b0;
        end else if (pending_values.size() != 0 &&
                     !(pending_values[0].drain_first && expected_text.size() != 0)) begin
          start_i <= 1'b1;
          value_i <= pending_values[0].value;
          void'(pending_values.pop_front());
        end else begin
          // Nothing to send, or hold until the output has drained.
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed byte must match the oldest predicted byte.
  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      if (expected_text.size() == 0) begin
        $display("%0t: unexpected byte: expected none, actual code %h last %b",
                 $time, text_byte_o, last_byte_o);
        error_count++;
      end else begin
        if (text_byte_o !== expected_text[0].code) begin
          $display("%0t: text_byte mismatch: expected %h, actual %h",
                   $time, expected_text[0].code, text_byte_o);
          error_count++;
        end
        if (last_byte_o !== expected_text[0].last) begin
          $display("%0t: last_byte mismatch: expected %b, actual %b",
                   $time, expected_text[0].last, last_byte_o);
          error_count++;
        end
        void'(expected_text.pop_front());
      end
    end
  end

  // Hold reset low at the start, then release it for good.
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Build the stimulus, wait for it to drain, and report.
  initial begin
    // Directed part: zero, single digits, several decade boundaries, the largest
    // value, and alternating bit patterns. Send back to back but for a short gap before 999.
    add_value('0, 0, 1'b0);
    add_value(VALUE_BITS'(1), 0, 1'b0);
    add_value(VALUE_BITS'(9), 0, 1'b0);
    add_value(VALUE_BITS'(10), 0, 1'b0);
    add_value(VALUE_BITS'(99), 0, 1'b0);
    add_value(VALUE_BITS'(100), 0, 1'b0);
    add_value(VALUE_BITS'(999), 2, 1'b0);
    add_value(VALUE_BITS'(1000), 0, 1'b0);
    add_value(VALUE_BITS'(99999), 0, 1'b0);
    add_value(VALUE_BITS'(100000), 0, 1'b0);
    add_value(VALUE_BITS'(9999999), 0, 1'b0);
    add_value(VALUE_BITS'(10000000), 0, 1'b0);
    add_value(VALUE_BITS'(999999999), 0, 1'b0);
    add_value(VALUE_BITS'(1000000000), 0, 1'b0);
    add_value(VALUE_MAX, 0, 1'b0);
    add_value({1'b0, {(VALUE_BITS - 1){1'b1}}}, 0, 1'b0);
    add_value({1'b1, {(VALUE_BITS - 1){1'b0}}}, 0, 1'b0);
    add_value(VALUE_BITS'(32'h5555_5555), 0, 1'b0);
    add_value(VALUE_BITS'(32'h2AAA_AAAA), 0, 1'b0);
    // Zero and the maximum again after a full drain.
    add_value('0, 5, 1'b1);
    add_value(VALUE_MAX, 0, 1'b0);

    // Random part; drain completely a few times, and keep one long stretch
    // with no idle cycles so the stages fill up behind the serializer.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i >= 100 && i < 130) begin
        add_value(random_value(), 0, 1'b0);
      end else begin
        add_value(random_value(), random_gap(), (i % 60) == 30);
      end
    end

    // Wait until every value is accepted and every byte has come out.
    while (pending_values.size() != 0 || start_i) begin
      @(posedge clk_i);
    end
    while (expected_text.size() != 0) begin
      @(posedge clk_i);
    end
    // Let any stray bytes surface before judging.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: stop a run that hangs.
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
